// ===== design/tpf_pkg.sv =====
// Shared types and constants for the TCP port range packet filter.
package tpf_pkg;

  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;
  localparam logic [COUNT_W-1:0] POS_ETYPE_HI   = 7'd12;
  localparam logic [COUNT_W-1:0] POS_ETYPE_LO   = 7'd13;
  localparam logic [COUNT_W-1:0] POS_IHL        = 7'd14;
  localparam logic [COUNT_W-1:0] POS_PROTO      = 7'd23;
  localparam logic [COUNT_W-1:0] POS_DADDR_LO   = 7'd30;
  localparam logic [COUNT_W-1:0] POS_DADDR_HI   = 7'd33;
  localparam logic [COUNT_W-1:0] POS_PORT_BASE  = 7'd16;
  localparam logic [COUNT_W-1:0] MIN_LENGTH     = 7'd34;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [31:0] RESET_MATCH_ADDRESS = 32'h7f00_0001;
  localparam logic [15:0] RESET_RANGE_LOW     = 16'd4000;
  localparam logic [15:0] RESET_RANGE_HIGH    = 16'd5000;
  localparam logic [15:0] RESET_ALLOWED_PORT  = 16'd4040;

  typedef enum logic [1:0] {
    REG_MATCH_ADDRESS = 2'd0,
    REG_RANGE_LOW     = 2'd1,
    REG_RANGE_HIGH    = 2'd2,
    REG_ALLOWED_PORT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] match_address;
    logic [15:0] range_low_port;
    logic [15:0] range_high_port;
    logic [15:0] allowed_port;
  } cfg_t;

  // Per-frame summary handed from the parser to the verdict stage.
  typedef struct packed {
    logic        len_ok;
    logic        tcp_ok;
    logic [31:0] dest_address;
    logic [15:0] dst_port;
  } frame_rec_t;

endpackage

// ===== design/tcp_port_range_packet_filter.sv =====
// TCP port range packet filter: byte-stream frame parser with per-frame drop verdict.
//
// Input side is a queue: frame bytes go in with push while full is low, one byte per
// item, frame_last high on the final byte of each frame. Result side is a queue too:
// while empty is low, drop_frame and port_in_range hold the verdict of the oldest
// finished frame, and pop takes it. Exactly one result comes out per frame.
// Throughput is one byte per cycle while full is low. A verdict reaches the result ports
// through registers: the parser writes a summary into a QUEUE_DEPTH-entry queue at the
// edge that takes its final byte, and the verdict stage moves it into the output
// register once that register is empty or being popped.
// When the receiver stalls, the output register holds, the queue fills with summaries
// of later frames, and full rises only once QUEUE_DEPTH summaries wait behind it.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the next edge
// and are to be made while no frame is in flight.
// Synchronous reset restores the default registers (127.0.0.1, ports 4000 to 5000,
// port 4040 allowed), clears the parser and empties both queues.
module tcp_port_range_packet_filter
  import tpf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  output logic        empty,
  input  logic        pop,
  output logic        drop_frame,
  output logic        port_in_range,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned REC_W = $bits(frame_rec_t);

  cfg_t       cfg;
  logic       accept;
  logic       rec_write;
  frame_rec_t rec;
  frame_rec_t head;
  logic [REC_W-1:0] head_bits;
  logic       q_read;
  logic       q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_address   <= RESET_MATCH_ADDRESS;
      cfg.range_low_port  <= RESET_RANGE_LOW;
      cfg.range_high_port <= RESET_RANGE_HIGH;
      cfg.allowed_port    <= RESET_ALLOWED_PORT;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MATCH_ADDRESS: cfg.match_address   <= cfg_data;
        REG_RANGE_LOW:     cfg.range_low_port  <= cfg_data[15:0];
        REG_RANGE_HIGH:    cfg.range_high_port <= cfg_data[15:0];
        REG_ALLOWED_PORT:  cfg.allowed_port    <= cfg_data[15:0];
      endcase
    end
  end

  assign accept = push && !full;

  tpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (frame_byte),
    .frame_last (frame_last),
    .rec_write  (rec_write),
    .rec        (rec)
  );

  tpf_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .write      (rec_write),
    .write_data (rec),
    .read       (q_read),
    .read_data  (head_bits),
    .full       (full),
    .empty      (q_empty)
  );

  assign head = frame_rec_t'(head_bits);

  tpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .q_empty       (q_empty),
    .q_read        (q_read),
    .pop           (pop),
    .empty         (empty),
    .drop_frame    (drop_frame),
    .port_in_range (port_in_range)
  );

`ifndef ASSERT_OFF
  a_drop_implies_range: assert property (@(posedge clk) disable iff (rst)
    !empty && drop_frame |-> port_in_range)
    else $error("drop verdict without port in range");

  a_last_queues_summary: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> !q_empty)
    else $error("final byte did not queue a frame summary");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> empty && !full && q_empty)
    else $error("queues not empty after reset");

  a_read_loads_output: assert property (@(posedge clk) disable iff (rst)
    q_read |=> !empty)
    else $error("summary read without a visible result");
`endif

endmodule

// ===== design/tpf_fifo.sv =====
// Small register FIFO between the frame parser and the verdict stage.
module tpf_fifo
  import tpf_pkg::*;
#(
  parameter int unsigned WIDTH = 50,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             write,
  input  logic [WIDTH-1:0] write_data,
  input  logic             read,
  output logic [WIDTH-1:0] read_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign read_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (write) begin
      mem[wr_ptr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (write) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (read) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (write && !read) begin
        count <= count + CNT_W'(1);
      end else if (read && !write) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/tpf_front.sv =====
// Frame parser: counts bytes, captures header fields, emits one summary per frame.
module tpf_front
  import tpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] frame_byte,
  input  logic       frame_last,
  output logic       rec_write,
  output frame_rec_t rec
);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        ether_type, ether_type_next;
  logic [3:0]         header_words, header_words_next;
  logic [7:0]         ip_protocol, ip_protocol_next;
  logic [31:0]        dest_address, dest_address_next;
  logic [15:0]        dst_port, dst_port_next;
  logic [COUNT_W-1:0] port_pos;
  logic [COUNT_W-1:0] hdr_len_min;

  always_comb begin
    port_pos          = POS_PORT_BASE + {1'b0, header_words, 2'b00};
    ether_type_next   = ether_type;
    header_words_next = header_words;
    ip_protocol_next  = ip_protocol;
    dest_address_next = dest_address;
    dst_port_next     = dst_port;

    if (byte_count == POS_ETYPE_HI || byte_count == POS_ETYPE_LO) begin
      ether_type_next = {ether_type[7:0], frame_byte};
    end
    if (byte_count == POS_IHL) begin
      header_words_next = frame_byte[3:0];
    end
    if (byte_count == POS_PROTO) begin
      ip_protocol_next = frame_byte;
    end
    if (byte_count >= POS_DADDR_LO && byte_count <= POS_DADDR_HI) begin
      dest_address_next = {dest_address[23:0], frame_byte};
    end
    if (byte_count == port_pos || byte_count == port_pos + COUNT_W'(1)) begin
      dst_port_next = {dst_port[7:0], frame_byte};
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + COUNT_W'(1);
    hdr_len_min     = MIN_LENGTH + {1'b0, header_words_next, 2'b00};

    rec.len_ok       = (byte_count_next >= MIN_LENGTH) && (byte_count_next >= hdr_len_min);
    rec.tcp_ok       = (ether_type_next == ETHERTYPE_IPV4) && (ip_protocol_next == PROTO_TCP);
    rec.dest_address = dest_address_next;
    rec.dst_port     = dst_port_next;
  end

  assign rec_write = accept && frame_last;

  always_ff @(posedge clk) begin
    if (rst || rec_write) begin
      byte_count   <= '0;
      ether_type   <= '0;
      header_words <= '0;
      ip_protocol  <= '0;
      dest_address <= '0;
      dst_port     <= '0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      ether_type   <= ether_type_next;
      header_words <= header_words_next;
      ip_protocol  <= ip_protocol_next;
      dest_address <= dest_address_next;
      dst_port     <= dst_port_next;
    end
  end

endmodule

// ===== design/tpf_back.sv =====
// Verdict stage: compares a frame summary against the configuration into an output register.
module tpf_back
  import tpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  frame_rec_t head,
  input  logic       q_empty,
  output logic       q_read,
  input  logic       pop,
  output logic       empty,
  output logic       drop_frame,
  output logic       port_in_range
);

  logic out_valid;
  logic in_range;
  logic drop;

  always_comb begin
    in_range = head.len_ok && head.tcp_ok && (head.dest_address == cfg.match_address)
               && (head.dst_port >= cfg.range_low_port)
               && (head.dst_port <= cfg.range_high_port);
    drop     = in_range && (head.dst_port != cfg.allowed_port);
  end

  assign q_read = !q_empty && (!out_valid || pop);
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_read) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_read) begin
      drop_frame    <= drop;
      port_in_range <= in_range;
    end
  end

endmodule

// ===== dv/filter_verdict_checker.sv =====
// Verdict checker for the TCP port range filter: predicts each frame verdict and compares it.
module filter_verdict_checker
  import tpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  input  logic        empty,
  input  logic        pop,
  input  logic        drop_frame,
  input  logic        port_in_range,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          verdicts_waiting
);

  typedef struct packed {
    logic drop;
    logic in_range;
  } verdict_t;

  cfg_t        cfg;
  logic [6:0]  seen_bytes;
  logic [15:0] etype;
  logic [3:0]  hdr_words;
  logic [7:0]  proto;
  logic [31:0] daddr;
  logic [15:0] dport;
  verdict_t    verdict_q[$];
  int          err_cnt = 0;

  task automatic clear_capture();
    seen_bytes = '0;
    etype      = '0;
    hdr_words  = '0;
    proto      = '0;
    daddr      = '0;
    dport      = '0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    int       pos;
    int       port_pos;
    int       flen;
    logic     ok;
    logic     hit;
    verdict_t v;
    pos      = int'(seen_bytes);
    port_pos = int'(POS_PORT_BASE) + 4 * int'(hdr_words);
    if (pos == int'(POS_ETYPE_HI) || pos == int'(POS_ETYPE_LO)) etype = {etype[7:0], b};
    if (pos == int'(POS_IHL)) hdr_words = b[3:0];
    if (pos == int'(POS_PROTO)) proto = b;
    if (pos >= int'(POS_DADDR_LO) && pos <= int'(POS_DADDR_HI)) daddr = {daddr[23:0], b};
    if (pos == port_pos || pos == port_pos + 1) dport = {dport[7:0], b};
    if (seen_bytes != COUNT_MAX) seen_bytes = seen_bytes + 7'd1;
    if (last) begin
      flen = int'(seen_bytes);
      ok = flen >= int'(MIN_LENGTH) && flen >= int'(MIN_LENGTH) + 4 * int'(hdr_words) &&
           etype == ETHERTYPE_IPV4 && proto == PROTO_TCP && daddr == cfg.match_address;
      hit = ok && dport >= cfg.range_low_port && dport <= cfg.range_high_port;
      v.in_range = hit;
      v.drop     = hit && dport != cfg.allowed_port;
      verdict_q.push_back(v);
      clear_capture();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      cfg = '{RESET_MATCH_ADDRESS, RESET_RANGE_LOW, RESET_RANGE_HIGH, RESET_ALLOWED_PORT};
      clear_capture();
      verdict_q.delete();
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_MATCH_ADDRESS: cfg.match_address   = cfg_data;
          REG_RANGE_LOW:     cfg.range_low_port  = cfg_data[15:0];
          REG_RANGE_HIGH:    cfg.range_high_port = cfg_data[15:0];
          REG_ALLOWED_PORT:  cfg.allowed_port    = cfg_data[15:0];
        endcase
      end
      if (push && !full) take_byte(frame_byte, frame_last);
      if (pop && !empty) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected item drop_frame=%0b port_in_range=%0b",
                   $time, drop_frame, port_in_range);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          if (drop_frame !== want.drop) begin
            $display("%0t: drop_frame expected %0b actual %0b", $time, want.drop, drop_frame);
            err_cnt++;
          end
          if (port_in_range !== want.in_range) begin
            $display("%0t: port_in_range expected %0b actual %0b",
                     $time, want.in_range, port_in_range);
            err_cnt++;
          end
        end
      end
    end
    mismatches       <= err_cnt;
    verdicts_waiting <= verdict_q.size();
  end

endmodule

// ===== dv/tb_tcp_port_range_packet_filter.sv =====
// Testbench top for the TCP port range filter: frame stimulus, result stalls and final verdict.
module tb_tcp_port_range_packet_filter;
  import tpf_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  frame_byte;
  logic        frame_last;
  logic        empty;
  logic        pop;
  logic        drop_frame;
  logic        port_in_range;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatches;
  int          verdicts_waiting;

  cfg_t        cur_cfg;
  logic [7:0]  frame_buf[$];
  int          burst_left;
  int          gap_left;
  bit          hold_go;

  tcp_port_range_packet_filter dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .frame_byte(frame_byte),
    .frame_last(frame_last), .empty(empty), .pop(pop), .drop_frame(drop_frame),
    .port_in_range(port_in_range), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  filter_verdict_checker verdict_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .frame_byte(frame_byte),
    .frame_last(frame_last), .empty(empty), .pop(pop), .drop_frame(drop_frame),
    .port_in_range(port_in_range), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .verdicts_waiting(verdicts_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tcp_port_range_packet_filter: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      push <= 1'b0;
      @(posedge clk);
      gap_left--;
    end
    push       <= 1'b1;
    frame_byte <= b;
    frame_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic make_noise(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic put_byte(input int idx, input logic [7:0] val);
    if (idx < frame_buf.size()) frame_buf[idx] = val;
  endtask

  // port goes in last, so with a short header it may overwrite earlier fields
  task automatic make_frame(input logic [31:0] addr, input logic [15:0] port, input int hw,
                            input int len, input logic [15:0] et, input logic [7:0] pr);
    int pp;
    make_noise(len);
    put_byte(12, et[15:8]);
    put_byte(13, et[7:0]);
    put_byte(14, {4'($urandom), 4'(hw)});
    put_byte(23, pr);
    for (int i = 0; i < 4; i++) put_byte(30 + i, addr[31 - 8 * i -: 8]);
    pp = 16 + 4 * hw;
    put_byte(pp, port[15:8]);
    put_byte(pp + 1, port[7:0]);
  endtask

  task automatic rand_frame();
    int          hw;
    int          len;
    logic [15:0] port;
    logic [31:0] addr;
    logic [15:0] et;
    logic [7:0]  pr;
    hw  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    len = 34 + 4 * hw + $urandom_range(0, 4);
    case ($urandom_range(0, 9))
      0:       len = 33 + 4 * hw;
      1:       len = $urandom_range(128, 132);
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: port = cur_cfg.range_low_port;
      1: port = cur_cfg.range_high_port;
      2: port = cur_cfg.range_low_port - 16'd1;
      3: port = cur_cfg.range_high_port + 16'd1;
      4: port = cur_cfg.allowed_port;
      5: port = cur_cfg.allowed_port + 16'd1;
      6: begin
        if (cur_cfg.range_low_port <= cur_cfg.range_high_port)
          port = cur_cfg.range_low_port +
                 16'($urandom_range(0, cur_cfg.range_high_port - cur_cfg.range_low_port));
        else
          port = 16'($urandom);
      end
      default: port = 16'($urandom);
    endcase
    addr = cur_cfg.match_address;
    if ($urandom_range(0, 7) == 0) addr = addr ^ (32'd1 << $urandom_range(0, 31));
    et = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
    pr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_TCP;
    make_frame(addr, port, hw, len, et, pr);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_MATCH_ADDRESS, c.match_address);
    write_reg(REG_RANGE_LOW, {16'd0, c.range_low_port});
    write_reg(REG_RANGE_HIGH, {16'd0, c.range_high_port});
    write_reg(REG_ALLOWED_PORT, {16'd0, c.allowed_port});
    cfg_write <= 1'b0;
    cur_cfg = c;
  endtask

  // result side
  initial begin
    int run;
    int pct;
    bit held;
    held = 1'b0;
    pop <= 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (800) @(posedge clk);
      end else begin
        run = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0:       pct = 100;
          1:       pct = 0;
          2:       pct = 50;
          default: pct = 85;
        endcase
        repeat (run) begin
          pop <= ($urandom_range(1, 100) <= pct);
          @(posedge clk);
        end
      end
    end
  end

  // frame side
  initial begin
    cfg_t        c;
    int          n_frames;
    logic [31:0] a;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] t;
    rst        <= 1'b1;
    push       <= 1'b0;
    frame_byte <= 8'd0;
    frame_last <= 1'b0;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_MATCH_ADDRESS;
    cfg_data   <= 32'd0;
    cur_cfg    = '{RESET_MATCH_ADDRESS, RESET_RANGE_LOW, RESET_RANGE_HIGH, RESET_ALLOWED_PORT};
    burst_left = 0;
    gap_left   = 0;
    hold_go    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    a = RESET_MATCH_ADDRESS;
    make_frame(a, 16'd4000, 0, 34, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd5000, 0, 34, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd3999, 0, 34, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd5001, 0, 34, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd4040, 0, 34, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd4500, 5, 54, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd4500, 5, 53, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd4500, 0, 33, ETHERTYPE_IPV4, PROTO_TCP);  send_frame();
    make_frame(a, 16'd4500, 15, 94, ETHERTYPE_IPV4, PROTO_TCP); send_frame();
    make_frame(a, 16'd4500, 0, 128, ETHERTYPE_IPV4, PROTO_TCP); send_frame();
    make_frame(a ^ 32'd1, 16'd4500, 0, 34, ETHERTYPE_IPV4, PROTO_TCP); send_frame();
    make_noise(1);                                              send_frame();

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: c = '{32'h0000_0000, 16'h0000, 16'hffff, 16'hffff};
        1: c = '{32'hffff_ffff, 16'hffff, 16'hffff, 16'h0000};
        2: c = '{32'($urandom), 16'd5000, 16'd4000, 16'd4500};
        3: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
          if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
          c = '{32'($urandom), lo, hi, lo + 16'($urandom_range(0, hi - lo))};
        end
        default: begin
          lo = 16'($urandom);
          hi = (lo > 16'd65532) ? 16'hffff : lo + 16'($urandom_range(0, 3));
          c  = '{32'($urandom), lo, hi, lo};
        end
      endcase
      load_config(c);
      if (p == 3) begin
        // short frames while the receiver holds off, so the block fills up
        hold_go = 1'b1;
        repeat (48) @(posedge clk);
        repeat (10) begin
          make_noise($urandom_range(1, 2));
          send_frame();
        end
      end
      n_frames = 0;
      while (n_frames < 2) begin
        if ($urandom_range(0, 3) == 0) make_noise($urandom_range(1, 40));
        else rand_frame();
        send_frame();
        n_frames++;
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (verdicts_waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tcp_port_range_packet_filter: match");
    end else begin
      $display("tcp_port_range_packet_filter: mismatch");
    end
    $finish;
  end

endmodule
